/* src/dnsaf_pkg.sv */
// Shared constants, codes and types for the DNS AAAA message filter.
package dnsaf_pkg;

   localparam int unsigned HEADER_BYTES = 12;

   localparam logic [15:0] WANTED_TYPE_RESET = 16'd28;
   localparam logic [3:0]  RCODE_MASK        = 4'hF;
   localparam logic [7:0]  QR_BIT            = 8'h80;
   localparam logic [7:0]  RCODE_REFUSED_OR  = 8'h04;
   localparam logic [7:0]  UNSUP_RCODE_BYTE  = 8'h84;
   localparam logic [7:0]  ANSWER_SKIP_BYTES = 8'd6;
   localparam logic [16:0] QUESTION_TAIL     = 17'd5;

   localparam logic [2:0] PH_HEADER  = 3'd0;
   localparam logic [2:0] PH_NAME    = 3'd1;
   localparam logic [2:0] PH_SKIP    = 3'd2;
   localparam logic [2:0] PH_TYPE_HI = 3'd3;
   localparam logic [2:0] PH_TYPE_LO = 3'd4;
   localparam logic [2:0] PH_DONE    = 3'd5;

   localparam logic [2:0] ACT_REQ_OK = 3'd0;
   localparam logic [2:0] ACT_RSP_OK = 3'd1;
   localparam logic [2:0] ACT_RCODE  = 3'd2;
   localparam logic [2:0] ACT_UNSUP  = 3'd3;
   localparam logic [2:0] ACT_STRIP  = 3'd4;
   localparam logic [2:0] ACT_BAD    = 3'd5;

   localparam logic [15:0] POS_FLAGS = 16'd2;
   localparam logic [15:0] POS_RCODE = 16'd3;
   localparam logic [15:0] POS_AN_HI = 16'd6;
   localparam logic [15:0] POS_AN_LO = 16'd7;
   localparam logic [15:0] POS_HDR_LAST = 16'(HEADER_BYTES - 1);

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } dnsaf_item_type;

   typedef struct packed {
      logic        forward_valid;
      logic [2:0]  action_code;
      logic [7:0]  flags_byte;
      logic [7:0]  rcode_byte;
      logic [15:0] answer_count;
      logic        clear_other_counts;
      logic [15:0] new_length;
      logic [15:0] record_type;
      logic [7:0]  name_length;
   } dnsaf_verdict_type;

endpackage

/* src/dnsaf_parser.sv */
// Byte-walk parser state for one DNS message and the end-of-message verdict.
module dnsaf_parser (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       take,
   input  dnsaf_pkg::dnsaf_item_type  item,
   input  logic [15:0]                wanted_type,
   output dnsaf_pkg::dnsaf_verdict_type verdict
);
   import dnsaf_pkg::*;

   logic [15:0] pos_ff, pos_in;
   logic [2:0]  phase_ff, phase_in;
   logic [7:0]  left_ff, left_in;
   logic [7:0]  flags_ff, flags_in;
   logic [7:0]  rcode_ff, rcode_in;
   logic [15:0] acount_ff, acount_in;
   logic [15:0] name_end_ff, name_end_in;
   logic [15:0] type_ff, type_in;
   logic [7:0]  nlen_ff, nlen_in;

   logic [9:0]  nlen_sum;
   logic [16:0] cut_len;
   logic        type_match;

   always_comb begin
      pos_in      = pos_ff;
      phase_in    = phase_ff;
      left_in     = left_ff;
      flags_in    = flags_ff;
      rcode_in    = rcode_ff;
      acount_in   = acount_ff;
      name_end_in = name_end_ff;
      type_in     = type_ff;
      nlen_in     = nlen_ff;
      nlen_sum    = {2'b00, nlen_ff} + {2'b00, item.data} + {9'd0, nlen_ff != 8'd0};
      unique case (phase_ff)
         PH_HEADER: begin
            if (pos_ff == POS_FLAGS) flags_in = item.data;
            else if (pos_ff == POS_RCODE) rcode_in = item.data;
            else if (pos_ff == POS_AN_HI) acount_in = {item.data, 8'd0};
            else if (pos_ff == POS_AN_LO) acount_in = {acount_ff[15:8], item.data};
            if (pos_ff >= POS_HDR_LAST) begin
               phase_in = ((rcode_ff[3:0] & RCODE_MASK) != 4'd0) ? PH_DONE : PH_NAME;
               left_in  = 8'd0;
            end
         end
         PH_NAME: begin
            if (left_ff != 8'd0) begin
               left_in = left_ff - 8'd1;
            end else if (item.data == 8'd0) begin
               name_end_in = pos_ff;
               if ((flags_ff & QR_BIT) != 8'd0) begin
                  left_in  = ANSWER_SKIP_BYTES;
                  phase_in = PH_SKIP;
               end else begin
                  phase_in = PH_TYPE_HI;
               end
            end else begin
               left_in = item.data;
               nlen_in = (nlen_sum > 10'd255) ? 8'hFF : nlen_sum[7:0];
            end
         end
         PH_SKIP: begin
            if (left_ff > 8'd1) begin
               left_in = left_ff - 8'd1;
            end else begin
               left_in  = 8'd0;
               phase_in = PH_TYPE_HI;
            end
         end
         PH_TYPE_HI: begin
            type_in  = {item.data, 8'd0};
            phase_in = PH_TYPE_LO;
         end
         PH_TYPE_LO: begin
            type_in  = {type_ff[15:8], item.data};
            phase_in = PH_DONE;
         end
         default: begin
         end
      endcase
      if (pos_ff != 16'hFFFF) pos_in = pos_ff + 16'd1;
   end

   assign type_match = (type_in == wanted_type);
   assign cut_len    = {1'b0, name_end_in} + QUESTION_TAIL;

   always_comb begin
      verdict.flags_byte         = flags_in;
      verdict.rcode_byte         = rcode_in;
      verdict.answer_count       = acount_in;
      verdict.clear_other_counts = 1'b0;
      verdict.new_length         = pos_in;
      verdict.record_type        = type_in;
      verdict.name_length        = nlen_in;
      if (phase_in == PH_HEADER) begin
         verdict.action_code = ACT_BAD;
      end else if ((rcode_in[3:0] & RCODE_MASK) != 4'd0) begin
         verdict.action_code = ACT_RCODE;
         verdict.rcode_byte  = rcode_in | RCODE_REFUSED_OR;
         verdict.record_type = 16'd0;
      end else if (phase_in != PH_DONE) begin
         verdict.action_code = ACT_BAD;
      end else if ((flags_in & QR_BIT) == 8'd0) begin
         if (type_match) begin
            verdict.action_code = ACT_REQ_OK;
         end else begin
            verdict.action_code = ACT_UNSUP;
            verdict.flags_byte  = flags_in | QR_BIT;
            verdict.rcode_byte  = UNSUP_RCODE_BYTE;
         end
      end else begin
         if (type_match) begin
            verdict.action_code = ACT_RSP_OK;
         end else begin
            verdict.action_code        = ACT_STRIP;
            verdict.rcode_byte         = rcode_in | RCODE_REFUSED_OR;
            verdict.answer_count       = 16'd0;
            verdict.clear_other_counts = 1'b1;
            verdict.new_length         = cut_len[16] ? 16'hFFFF : cut_len[15:0];
         end
      end
      if (verdict.action_code == ACT_BAD) begin
         verdict.answer_count = 16'd0;
         verdict.record_type  = 16'd0;
      end
      verdict.forward_valid = (verdict.action_code == ACT_REQ_OK) ||
                              (verdict.action_code == ACT_RSP_OK);
   end

   always_ff @(posedge clock) begin
      if (reset || (take && item.last)) begin
         pos_ff      <= 16'd0;
         phase_ff    <= PH_HEADER;
         left_ff     <= 8'd0;
         flags_ff    <= 8'd0;
         rcode_ff    <= 8'd0;
         acount_ff   <= 16'd0;
         name_end_ff <= 16'd0;
         type_ff     <= 16'd0;
         nlen_ff     <= 8'd0;
      end else if (take) begin
         pos_ff      <= pos_in;
         phase_ff    <= phase_in;
         left_ff     <= left_in;
         flags_ff    <= flags_in;
         rcode_ff    <= rcode_in;
         acount_ff   <= acount_in;
         name_end_ff <= name_end_in;
         type_ff     <= type_in;
         nlen_ff     <= nlen_in;
      end
   end

endmodule

/* src/dns_aaaa_packet_filter.sv */
// Top level of the DNS AAAA message filter: input register, parser, result register.
// rsp_valid shows the verdict once the result register takes it with the last byte.
// Throughput: one byte per cycle; bytes that end no message flow on even while a
// verdict waits, only a last byte waits for the result register to free up.
// Reset clears the parser to the header phase, empties both registers and sets
// the wanted record type to 28.
module dns_aaaa_packet_filter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_packet_byte,
   input  logic        req_end_of_packet,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_forward_valid,
   output logic [2:0]  rsp_action_code,
   output logic [7:0]  rsp_flags_byte_out,
   output logic [7:0]  rsp_rcode_byte_out,
   output logic [15:0] rsp_answer_count_out,
   output logic        rsp_clear_other_counts,
   output logic [15:0] rsp_new_length,
   output logic [15:0] rsp_record_type_seen,
   output logic [7:0]  rsp_name_length,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data
);
   import dnsaf_pkg::*;

   logic              in_valid_ff, in_valid_in;
   dnsaf_item_type    in_item_ff;
   logic              out_valid_ff, out_valid_in;
   dnsaf_verdict_type out_ff;
   dnsaf_verdict_type verdict;
   logic [15:0]       wanted_ff;
   logic              out_free;
   logic              take;

   assign out_free    = !out_valid_ff || !rsp_stall;
   assign take        = in_valid_ff && (!in_item_ff.last || out_free);
   assign req_stall   = in_valid_ff && !take;
   assign in_valid_in = req_valid || (in_valid_ff && !take);
   assign out_valid_in = (take && in_item_ff.last) || (out_valid_ff && rsp_stall);

   dnsaf_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .item        (in_item_ff),
      .wanted_type (wanted_ff),
      .verdict     (verdict)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         wanted_ff    <= WANTED_TYPE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_write_enable) wanted_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_item_ff.data <= req_packet_byte;
         in_item_ff.last <= req_end_of_packet;
      end
      if (take && in_item_ff.last) out_ff <= verdict;
   end

   assign rsp_valid              = out_valid_ff;
   assign rsp_forward_valid      = out_ff.forward_valid;
   assign rsp_action_code        = out_ff.action_code;
   assign rsp_flags_byte_out     = out_ff.flags_byte;
   assign rsp_rcode_byte_out     = out_ff.rcode_byte;
   assign rsp_answer_count_out   = out_ff.answer_count;
   assign rsp_clear_other_counts = out_ff.clear_other_counts;
   assign rsp_new_length         = out_ff.new_length;
   assign rsp_record_type_seen   = out_ff.record_type;
   assign rsp_name_length        = out_ff.name_length;

endmodule

/* src/dnsaf_checker.sv */
// Port-level checks for the DNS AAAA message filter and their bind.
module dnsaf_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_forward_valid,
   input logic [2:0]  rsp_action_code,
   input logic [15:0] rsp_answer_count_out,
   input logic        rsp_clear_other_counts,
   input logic [15:0] rsp_new_length,
   input logic [15:0] rsp_record_type_seen
);
   import dnsaf_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_action_code) &&
         $stable(rsp_new_length) && $stable(rsp_record_type_seen))
      else $error("stalled item changed");

   a_forward_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_forward_valid ==
         ((rsp_action_code == ACT_REQ_OK) || (rsp_action_code == ACT_RSP_OK)))
      else $error("forward flag disagrees with action code");

   a_strip_counts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_clear_other_counts == (rsp_action_code == ACT_STRIP))
      else $error("count clear without answer strip");

   a_no_answers: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_action_code == ACT_STRIP) || (rsp_action_code == ACT_BAD))
         |-> rsp_answer_count_out == 16'd0)
      else $error("answer count kept on strip or malformed item");

   a_type_cleared: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_action_code == ACT_RCODE) || (rsp_action_code == ACT_BAD))
         |-> rsp_record_type_seen == 16'd0)
      else $error("record type reported without a parsed type");

endmodule

bind dns_aaaa_packet_filter dnsaf_checker u_dnsaf_checker (.*);

/* tb/tb_dns_aaaa_packet_filter.sv */
// Self-checking testbench for the DNS AAAA message filter: byte stream in, verdict out.
module tb_dns_aaaa_packet_filter;
   timeunit 1ns;
   timeprecision 1ps;

   import dnsaf_pkg::*;

   typedef struct {
      logic [7:0]  flags;
      logic [7:0]  rcode;
      logic [15:0] ancount;
      logic [2:0]  phase;
      logic [15:0] pos;
      logic [7:0]  left;
      logic [15:0] name_end;
      logic [15:0] rec_type;
      logic [7:0]  name_len;
   } parse_state_t;

   typedef struct {
      logic [7:0]        flags;
      logic [7:0]        rcode;
      logic [15:0]       ancount;
      int                labels;
      int                label_len;
      logic [15:0]       rec_type;
      int                trail;
      int                cut;
      bit                literal;
      dnsaf_verdict_type verdict;
   } msg_row_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_packet_byte = 8'h00;
   logic        req_end_of_packet = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_forward_valid;
   logic [2:0]  rsp_action_code;
   logic [7:0]  rsp_flags_byte_out;
   logic [7:0]  rsp_rcode_byte_out;
   logic [15:0] rsp_answer_count_out;
   logic        rsp_clear_other_counts;
   logic [15:0] rsp_new_length;
   logic [15:0] rsp_record_type_seen;
   logic [7:0]  rsp_name_length;
   logic        csr_write_enable = 1'b0;
   logic [15:0] csr_write_data = 16'h0000;

   parse_state_t      ps;
   logic [15:0]       wanted_type;
   dnsaf_verdict_type expected_verdicts[$];
   logic [7:0]        msg_bytes[$];
   int                error_count = 0;
   int                byte_count = 0;
   int                sender_idle_pct = 0;
   int                recv_stall_pct = 0;
   int                hold_left = 0;

   msg_row_t directed_rows [21] = '{
      '{8'h00, 8'h00, 16'h0000, 1, 3, 16'd28, 0, 1, 1'b1,
        '{1'b0, ACT_BAD, 8'h00, 8'h00, 16'd0, 1'b0, 16'd1, 16'd0, 8'd0}},
      '{8'h81, 8'h0F, 16'h1234, 1, 3, 16'd28, 0, 11, 1'b1,
        '{1'b0, ACT_BAD, 8'h81, 8'h0F, 16'd0, 1'b0, 16'd11, 16'd0, 8'd0}},
      '{8'h00, 8'h00, 16'h0000, 1, 3, 16'd28, 0, 12, 1'b1,
        '{1'b0, ACT_BAD, 8'h00, 8'h00, 16'd0, 1'b0, 16'd12, 16'd0, 8'd0}},
      '{8'h80, 8'h83, 16'h0002, 1, 3, 16'd28, 0, 0, 1'b1,
        '{1'b0, ACT_RCODE, 8'h80, 8'h87, 16'd2, 1'b0, 16'd25, 16'd0, 8'd0}},
      '{8'h00, 8'h01, 16'hFFFF, 1, 3, 16'd28, 0, 12, 1'b1,
        '{1'b0, ACT_RCODE, 8'h00, 8'h05, 16'hFFFF, 1'b0, 16'd12, 16'd0, 8'd0}},
      '{8'h01, 8'h00, 16'h0000, 2, 3, 16'd28, 0, 0, 1'b1,
        '{1'b1, ACT_REQ_OK, 8'h01, 8'h00, 16'd0, 1'b0, 16'd25, 16'd28, 8'd7}},
      '{8'h00, 8'h20, 16'h0000, 1, 5, 16'd1, 0, 0, 1'b1,
        '{1'b0, ACT_UNSUP, 8'h80, 8'h84, 16'd0, 1'b0, 16'd23, 16'd1, 8'd5}},
      '{8'h81, 8'h80, 16'h0001, 1, 4, 16'd28, 0, 0, 1'b1,
        '{1'b1, ACT_RSP_OK, 8'h81, 8'h80, 16'd1, 1'b0, 16'd26, 16'd28, 8'd4}},
      '{8'h84, 8'h00, 16'h0003, 1, 4, 16'd1, 10, 0, 1'b1,
        '{1'b0, ACT_STRIP, 8'h84, 8'h04, 16'd0, 1'b1, 16'd22, 16'd1, 8'd4}},
      '{8'h7F, 8'hF0, 16'h0000, 0, 1, 16'd28, 0, 0, 1'b0, '0},
      '{8'hFF, 8'hF0, 16'hFFFF, 0, 1, 16'hFFFF, 0, 0, 1'b0, '0},
      '{8'h00, 8'h00, 16'h0001, 1, 192, 16'd28, 0, 0, 1'b0, '0},
      '{8'h00, 8'h00, 16'h0000, 2, 128, 16'h0000, 0, 0, 1'b0, '0},
      '{8'h80, 8'h00, 16'h8000, 3, 63, 16'd28, 0, 0, 1'b0, '0},
      '{8'h00, 8'h00, 16'h0000, 1, 3, 16'd28, 0, 13, 1'b0, '0},
      '{8'h00, 8'h00, 16'h0000, 1, 3, 16'd28, 0, 18, 1'b0, '0},
      '{8'h80, 8'h00, 16'h0001, 1, 3, 16'd28, 0, 20, 1'b0, '0},
      '{8'h80, 8'h00, 16'h0001, 1, 3, 16'd28, 0, 24, 1'b0, '0},
      '{8'h00, 8'h00, 16'h0000, 2, 2, 16'd28, 6, 0, 1'b0, '0},
      '{8'h00, 8'h00, 16'h0005, 1, 3, 16'd28, 3, 0, 1'b0, '0},
      '{8'h00, 8'h00, 16'h0000, 1, 3, 16'h011C, 0, 0, 1'b0, '0}
   };

   dns_aaaa_packet_filter u_top (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_packet_byte        (req_packet_byte),
      .req_end_of_packet      (req_end_of_packet),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_forward_valid      (rsp_forward_valid),
      .rsp_action_code        (rsp_action_code),
      .rsp_flags_byte_out     (rsp_flags_byte_out),
      .rsp_rcode_byte_out     (rsp_rcode_byte_out),
      .rsp_answer_count_out   (rsp_answer_count_out),
      .rsp_clear_other_counts (rsp_clear_other_counts),
      .rsp_new_length         (rsp_new_length),
      .rsp_record_type_seen   (rsp_record_type_seen),
      .rsp_name_length        (rsp_name_length),
      .csr_write_enable       (csr_write_enable),
      .csr_write_data         (csr_write_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #2000000;
      $display("FAIL");
      $finish;
   end

   function automatic void restart_message();
      ps = '{8'h00, 8'h00, 16'h0000, PH_HEADER, 16'h0000, 8'h00, 16'h0000, 16'h0000, 8'h00};
   endfunction

   function automatic void dns_parse_byte(logic [7:0] b);
      logic [8:0] sum;
      case (ps.phase)
         PH_HEADER: begin
            if (ps.pos == POS_FLAGS) ps.flags = b;
            else if (ps.pos == POS_RCODE) ps.rcode = b;
            else if (ps.pos == POS_AN_HI) ps.ancount = {b, 8'h00};
            else if (ps.pos == POS_AN_LO) ps.ancount[7:0] = b;
            if (ps.pos >= POS_HDR_LAST) begin
               ps.phase = ((ps.rcode[3:0] & RCODE_MASK) != 0) ? PH_DONE : PH_NAME;
               ps.left = 8'h00;
            end
         end
         PH_NAME: begin
            if (ps.left != 0) begin
               ps.left = ps.left - 8'd1;
            end else if (b == 8'h00) begin
               ps.name_end = ps.pos;
               if ((ps.flags & QR_BIT) != 0) begin
                  ps.left = ANSWER_SKIP_BYTES;
                  ps.phase = PH_SKIP;
               end else begin
                  ps.phase = PH_TYPE_HI;
               end
            end else begin
               ps.left = b;
               sum = 9'(ps.name_len) + 9'(b) + ((ps.name_len != 0) ? 9'd1 : 9'd0);
               ps.name_len = sum[8] ? 8'hFF : sum[7:0];
            end
         end
         PH_SKIP: begin
            if (ps.left > 1) begin
               ps.left = ps.left - 8'd1;
            end else begin
               ps.left = 8'h00;
               ps.phase = PH_TYPE_HI;
            end
         end
         PH_TYPE_HI: begin
            ps.rec_type = {b, 8'h00};
            ps.phase = PH_TYPE_LO;
         end
         PH_TYPE_LO: begin
            ps.rec_type[7:0] = b;
            ps.phase = PH_DONE;
         end
         default: begin
         end
      endcase
      if (ps.pos != 16'hFFFF) ps.pos = ps.pos + 16'd1;
   endfunction

   function automatic dnsaf_verdict_type dns_verdict();
      dnsaf_verdict_type v;
      logic [16:0]       tail;
      v.forward_valid = 1'b0;
      v.flags_byte = ps.flags;
      v.rcode_byte = ps.rcode;
      v.answer_count = ps.ancount;
      v.clear_other_counts = 1'b0;
      v.new_length = ps.pos;
      v.record_type = ps.rec_type;
      v.name_length = ps.name_len;
      if (ps.phase == PH_HEADER) begin
         v.action_code = ACT_BAD;
      end else if ((ps.rcode[3:0] & RCODE_MASK) != 0) begin
         v.action_code = ACT_RCODE;
         v.rcode_byte = ps.rcode | RCODE_REFUSED_OR;
         v.record_type = 16'h0000;
      end else if (ps.phase != PH_DONE) begin
         v.action_code = ACT_BAD;
      end else if ((ps.flags & QR_BIT) == 0) begin
         if (ps.rec_type != wanted_type) begin
            v.action_code = ACT_UNSUP;
            v.flags_byte = ps.flags | QR_BIT;
            v.rcode_byte = UNSUP_RCODE_BYTE;
         end else begin
            v.action_code = ACT_REQ_OK;
         end
      end else if (ps.rec_type != wanted_type) begin
         v.action_code = ACT_STRIP;
         v.rcode_byte = ps.rcode | RCODE_REFUSED_OR;
         v.answer_count = 16'h0000;
         v.clear_other_counts = 1'b1;
         tail = {1'b0, ps.name_end} + QUESTION_TAIL;
         v.new_length = tail[16] ? 16'hFFFF : tail[15:0];
      end else begin
         v.action_code = ACT_RSP_OK;
      end
      if (v.action_code == ACT_BAD) begin
         v.answer_count = 16'h0000;
         v.record_type = 16'h0000;
      end
      v.forward_valid = (v.action_code == ACT_REQ_OK) || (v.action_code == ACT_RSP_OK);
      restart_message();
      return v;
   endfunction

   function automatic void build_message(logic [7:0] flags, logic [7:0] rcode,
                                         logic [15:0] ancount, int labels, int label_len,
                                         logic [15:0] rec_type, int trail, int cut);
      int len;
      msg_bytes.delete();
      msg_bytes.push_back(8'($urandom));
      msg_bytes.push_back(8'($urandom));
      msg_bytes.push_back(flags);
      msg_bytes.push_back(rcode);
      repeat (2) msg_bytes.push_back(8'($urandom));
      msg_bytes.push_back(ancount[15:8]);
      msg_bytes.push_back(ancount[7:0]);
      repeat (4) msg_bytes.push_back(8'($urandom));
      for (int i = 0; i < labels; i++) begin
         len = (label_len > 0) ? label_len : $urandom_range(1, 8);
         msg_bytes.push_back(8'(len));
         repeat (len) msg_bytes.push_back(8'($urandom));
      end
      msg_bytes.push_back(8'h00);
      if ((flags & QR_BIT) != 0) begin
         repeat (4) msg_bytes.push_back(8'($urandom));
         msg_bytes.push_back(8'hC0);
         msg_bytes.push_back(8'h0C);
      end
      msg_bytes.push_back(rec_type[15:8]);
      msg_bytes.push_back(rec_type[7:0]);
      if ((flags & QR_BIT) == 0) repeat (2) msg_bytes.push_back(8'($urandom));
      repeat (trail) msg_bytes.push_back(8'($urandom));
      if (cut > 0) while (msg_bytes.size() > cut) void'(msg_bytes.pop_back());
   endfunction

   function automatic void build_cut();
      int cut;
      cut = $urandom_range(1, msg_bytes.size() - 1);
      while (msg_bytes.size() > cut) void'(msg_bytes.pop_back());
   endfunction

   function automatic void make_random_message();
      int          roll;
      int          label_len;
      int          trail;
      logic [7:0]  flags;
      logic [7:0]  rcode;
      logic [15:0] rec_type;
      roll = $urandom_range(99);
      flags = 8'($urandom);
      rcode = {4'($urandom), 4'h0};
      label_len = ($urandom_range(24) == 0) ? $urandom_range(64, 255) : 0;
      trail = ($urandom_range(3) == 0) ? $urandom_range(1, 6) : 0;
      case ($urandom_range(3))
         0, 1: rec_type = wanted_type;
         2: rec_type = 16'($urandom);
         default: rec_type = wanted_type ^ (16'd1 << $urandom_range(15));
      endcase
      if (roll >= 88) begin
         msg_bytes.delete();
         repeat ($urandom_range(1, 30)) msg_bytes.push_back(8'($urandom));
      end else begin
         if (roll >= 60 && roll < 72) rcode[3:0] = 4'($urandom_range(1, 15));
         build_message(flags, rcode, 16'($urandom), $urandom_range(0, 3), label_len,
                       rec_type, trail, 0);
         if (roll >= 72 || (roll >= 60 && $urandom_range(1) == 0))
            build_cut();
      end
   endfunction

   task automatic note_mismatch(string what, logic [15:0] got, logic [15:0] want);
      $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
      error_count++;
   endtask

   task automatic send_byte(logic [7:0] b, logic is_last, bit literal,
                            dnsaf_verdict_type verdict);
      dnsaf_verdict_type v;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         req_packet_byte <= 8'($urandom);
         req_end_of_packet <= 1'($urandom);
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_packet_byte <= b;
      req_end_of_packet <= is_last;
      do @(posedge clock); while (req_stall);
      byte_count++;
      dns_parse_byte(b);
      if (is_last) begin
         v = dns_verdict();
         expected_verdicts.push_back(literal ? verdict : v);
      end
      @(negedge clock);
   endtask

   task automatic send_message(bit literal, dnsaf_verdict_type verdict);
      for (int i = 0; i < msg_bytes.size(); i++)
         send_byte(msg_bytes[i], i == msg_bytes.size() - 1, literal, verdict);
   endtask

   task automatic drain_verdicts();
      req_valid <= 1'b0;
      while (expected_verdicts.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_wanted_type(logic [15:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      wanted_type = value;
   endtask

   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      dnsaf_verdict_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_verdicts.size() == 0) begin
            note_mismatch("verdict with none pending", 16'd1, 16'd0);
         end else begin
            w = expected_verdicts.pop_front();
            if (rsp_forward_valid !== w.forward_valid)
               note_mismatch("forward_valid", 16'(rsp_forward_valid),
                             16'(w.forward_valid));
            if (rsp_action_code !== w.action_code)
               note_mismatch("action_code", 16'(rsp_action_code), 16'(w.action_code));
            if (rsp_flags_byte_out !== w.flags_byte)
               note_mismatch("flags_byte_out", 16'(rsp_flags_byte_out),
                             16'(w.flags_byte));
            if (rsp_rcode_byte_out !== w.rcode_byte)
               note_mismatch("rcode_byte_out", 16'(rsp_rcode_byte_out),
                             16'(w.rcode_byte));
            if (rsp_answer_count_out !== w.answer_count)
               note_mismatch("answer_count_out", rsp_answer_count_out, w.answer_count);
            if (rsp_clear_other_counts !== w.clear_other_counts)
               note_mismatch("clear_other_counts", 16'(rsp_clear_other_counts),
                             16'(w.clear_other_counts));
            if (rsp_new_length !== w.new_length)
               note_mismatch("new_length", rsp_new_length, w.new_length);
            if (rsp_record_type_seen !== w.record_type)
               note_mismatch("record_type_seen", rsp_record_type_seen, w.record_type);
            if (rsp_name_length !== w.name_length)
               note_mismatch("name_length", 16'(rsp_name_length), 16'(w.name_length));
         end
      end
   end

   initial begin
      int          phase_start;
      logic [15:0] cfg_value;
      restart_message();
      wanted_type = WANTED_TYPE_RESET;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i]) begin
         build_message(directed_rows[i].flags, directed_rows[i].rcode,
                       directed_rows[i].ancount, directed_rows[i].labels,
                       directed_rows[i].label_len, directed_rows[i].rec_type,
                       directed_rows[i].trail, directed_rows[i].cut);
         send_message(directed_rows[i].literal, directed_rows[i].verdict);
      end
      drain_verdicts();

      for (int p = 0; p < 4; p++) begin
         case (p)
            0: cfg_value = 16'hFFFF;
            1: cfg_value = 16'h0000;
            2: cfg_value = 16'($urandom);
            default: cfg_value = WANTED_TYPE_RESET;
         endcase
         write_wanted_type(cfg_value);
         sender_idle_pct = (p == 1) ? 85 : (p == 3) ? 6 : 0;
         recv_stall_pct = (p == 2) ? 85 : (p == 3) ? 6 : 0;
         if (p == 0) hold_left = 300;
         phase_start = byte_count;
         while (byte_count - phase_start < 160) begin
            make_random_message();
            send_message(1'b0, '0);
         end
         drain_verdicts();
      end

      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
